>>> hdl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/bmhq_pkg.sv
package bmhq_pkg;

  localparam int DEPTH    = 1024;
  localparam int TAG_BITS = 16;

  localparam int KEY_W    = 64;
  localparam int TAG_W    = 16;
  localparam int STS_W    = 2;
  localparam int OCC_W    = 11;

  localparam int TAG_KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int POS_W    = $clog2(2 * DEPTH + 2);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP_LOAD,
    S_POP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_KEEP-1:0]     tag;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic push_step;
    logic pop_load;
    logic pop_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic push_done;
    logic pop_done;
    logic out_free;
  } sts_t;

  // even tag wins a tie on equal keys
  function automatic logic precedes(input logic signed [KEY_W-1:0] ka,
                                    input logic ta_lsb,
                                    input logic signed [KEY_W-1:0] kb);
    return (ka == kb) ? !ta_lsb : (ka < kb);
  endfunction

endpackage

>>> hdl/bmhq_ctrl.sv
module bmhq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  bmhq_pkg::sts_t  sts,
  output bmhq_pkg::cmd_t  cmd
);

  bmhq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmhq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bmhq_pkg::S_IDLE: begin
        if (req_valid) begin
          if ((sts.is_pop && sts.empty) || (!sts.is_pop && sts.full)) begin
            state_next = bmhq_pkg::S_DONE;
          end else if (sts.is_pop) begin
            state_next = bmhq_pkg::S_POP_LOAD;
          end else begin
            state_next = bmhq_pkg::S_PUSH;
          end
        end
      end
      bmhq_pkg::S_PUSH: begin
        if (sts.push_done) state_next = bmhq_pkg::S_DONE;
      end
      bmhq_pkg::S_POP_LOAD: begin
        state_next = bmhq_pkg::S_POP;
      end
      bmhq_pkg::S_POP: begin
        if (sts.pop_done) state_next = bmhq_pkg::S_DONE;
      end
      bmhq_pkg::S_DONE: begin
        if (sts.out_free) state_next = bmhq_pkg::S_IDLE;
      end
      default: begin
        state_next = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      bmhq_pkg::S_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      bmhq_pkg::S_PUSH: begin
        cmd.push_step = 1'b1;
      end
      bmhq_pkg::S_POP_LOAD: begin
        cmd.pop_load = 1'b1;
      end
      bmhq_pkg::S_POP: begin
        cmd.pop_step = 1'b1;
      end
      bmhq_pkg::S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> hdl/bmhq_dp.sv
module bmhq_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bmhq_pkg::cmd_t                         cmd,
  output bmhq_pkg::sts_t                         sts,
  input  logic                                   kind,
  input  logic signed [bmhq_pkg::KEY_W-1:0]      key,
  input  logic [bmhq_pkg::TAG_W-1:0]             tag,
  output logic                                   rsp_valid,
  input  logic                                   rsp_ready,
  output logic [bmhq_pkg::STS_W-1:0]             status,
  output logic signed [bmhq_pkg::KEY_W-1:0]      out_key,
  output logic [bmhq_pkg::TAG_W-1:0]             out_tag,
  output logic [bmhq_pkg::OCC_W-1:0]             occupancy
);

  bmhq_pkg::entry_t mem [bmhq_pkg::DEPTH];
  bmhq_pkg::entry_t rd_a, rd_b, cur, child, wdata;

  logic [bmhq_pkg::CNT_W-1:0]  cnt, idx, par, push_par;
  logic [bmhq_pkg::POS_W-1:0]  chd, cpos, n_ext;
  logic [bmhq_pkg::ADDR_W-1:0] addr_a, addr_b, waddr;
  logic                        we, sel_right, full, empty, is_pop;

  bmhq_pkg::status_t               res_status;
  logic signed [bmhq_pkg::KEY_W-1:0] res_key;
  logic [bmhq_pkg::TAG_KEEP-1:0]   res_tag;

  assign is_pop   = (kind == bmhq_pkg::KIND_POP);
  assign full     = (cnt == bmhq_pkg::CNT_W'(bmhq_pkg::DEPTH));
  assign empty    = (cnt == '0);
  assign par      = idx >> 1;
  assign push_par = (cnt + bmhq_pkg::CNT_W'(1)) >> 1;
  assign n_ext    = bmhq_pkg::POS_W'(cnt);

  // sift-down child choice
  assign sel_right = (chd < n_ext) && bmhq_pkg::precedes(rd_b.key, rd_b.tag[0], rd_a.key);
  assign child     = sel_right ? rd_b : rd_a;
  assign cpos      = sel_right ? chd + bmhq_pkg::POS_W'(1) : chd;

  assign sts.is_pop    = is_pop;
  assign sts.full      = full;
  assign sts.empty     = empty;
  assign sts.push_done = (par == '0) || !bmhq_pkg::precedes(cur.key, cur.tag[0], rd_a.key);
  assign sts.pop_done  = (chd > n_ext) || !bmhq_pkg::precedes(child.key, child.tag[0], cur.key);
  assign sts.out_free  = !rsp_valid || rsp_ready;

  // memory addressing, position p lives at address p - 1
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    we     = 1'b0;
    waddr  = bmhq_pkg::ADDR_W'(idx - bmhq_pkg::CNT_W'(1));
    wdata  = cur;
    if (cmd.accept) begin
      if (!is_pop) begin
        addr_a = bmhq_pkg::ADDR_W'(push_par - bmhq_pkg::CNT_W'(1));
      end else begin
        addr_b = bmhq_pkg::ADDR_W'(cnt - bmhq_pkg::CNT_W'(1));
      end
    end
    if (cmd.pop_load) begin
      addr_a = bmhq_pkg::ADDR_W'(1);
      addr_b = bmhq_pkg::ADDR_W'(2);
    end
    if (cmd.push_step) begin
      we = 1'b1;
      if (!sts.push_done) begin
        wdata  = rd_a;
        addr_a = bmhq_pkg::ADDR_W'((par >> 1) - bmhq_pkg::CNT_W'(1));
      end
    end
    if (cmd.pop_step) begin
      we = 1'b1;
      if (!sts.pop_done) begin
        wdata  = child;
        addr_a = bmhq_pkg::ADDR_W'((cpos << 1) - bmhq_pkg::POS_W'(1));
        addr_b = bmhq_pkg::ADDR_W'(cpos << 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (!is_pop && !full) cnt <= cnt + bmhq_pkg::CNT_W'(1);
        if (is_pop && !empty) cnt <= cnt - bmhq_pkg::CNT_W'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur.key <= key;
      cur.tag <= tag[bmhq_pkg::TAG_KEEP-1:0];
      idx     <= cnt + bmhq_pkg::CNT_W'(1);
      res_key <= '0;
      res_tag <= '0;
      if (is_pop && empty) begin
        res_status <= bmhq_pkg::ST_EMPTY;
      end else if (!is_pop && full) begin
        res_status <= bmhq_pkg::ST_FULL;
      end else begin
        res_status <= bmhq_pkg::ST_OK;
      end
    end
    if (cmd.pop_load) begin
      res_key <= rd_a.key;
      res_tag <= rd_a.tag;
      cur     <= rd_b;
      idx     <= bmhq_pkg::CNT_W'(1);
      chd     <= bmhq_pkg::POS_W'(2);
    end
    if (cmd.push_step && !sts.push_done) begin
      idx <= par;
    end
    if (cmd.pop_step && !sts.pop_done) begin
      idx <= bmhq_pkg::CNT_W'(cpos);
      chd <= cpos << 1;
    end
    if (cmd.out_load) begin
      status    <= res_status;
      out_key   <= res_key;
      out_tag   <= bmhq_pkg::TAG_W'(res_tag);
      occupancy <= bmhq_pkg::OCC_W'(cnt);
    end
  end

endmodule

>>> hdl/binary_min_heap_queue.sv
// Binary min-heap priority queue of up to 1024 entries, each a signed 64-bit
// key with a 16-bit tag. A request is a push (kind 0) or a pop (kind 1);
// every request gives exactly one response with a status, the popped key and
// tag (zero unless a pop succeeded) and the entry count after the request.
// Ordering is by signed key, and on equal keys an entry with an even tag
// counts as first. Pop on an empty heap and push on a full heap report an
// error status and leave the heap unchanged. One request is worked at a
// time: the heap sits in a single memory with one write and two read ports
// and registered read data, and the sift loop handles one heap level per
// cycle, moving an entry by 0 to 10 levels. The next request is taken the
// cycle after the response is loaded, even if the response is still
// waiting to be taken.
module binary_min_heap_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              kind,
  input  logic signed [bmhq_pkg::KEY_W-1:0] key,
  input  logic [bmhq_pkg::TAG_W-1:0]        tag,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [bmhq_pkg::STS_W-1:0]        status,
  output logic signed [bmhq_pkg::KEY_W-1:0] out_key,
  output logic [bmhq_pkg::TAG_W-1:0]        out_tag,
  output logic [bmhq_pkg::OCC_W-1:0]        occupancy
);

  bmhq_pkg::cmd_t cmd;
  bmhq_pkg::sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmhq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .kind      (kind),
    .key       (key),
    .tag       (tag),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .occupancy (occupancy)
  );

endmodule

>>> hdl/bmhq_checker.sv
`include "assert_macros.svh"

module bmhq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              kind,
  input logic signed [bmhq_pkg::KEY_W-1:0] key,
  input logic [bmhq_pkg::TAG_W-1:0]        tag,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [bmhq_pkg::STS_W-1:0]        status,
  input logic signed [bmhq_pkg::KEY_W-1:0] out_key,
  input logic [bmhq_pkg::TAG_W-1:0]        out_tag,
  input logic [bmhq_pkg::OCC_W-1:0]        occupancy
);

  logic req_stall, rsp_stall, rsp_err, rsp_empty, rsp_full;
  logic [bmhq_pkg::KEY_W+bmhq_pkg::TAG_W:0] req_word;
  logic [bmhq_pkg::STS_W+bmhq_pkg::KEY_W+bmhq_pkg::TAG_W+bmhq_pkg::OCC_W-1:0] rsp_word;

  assign req_stall = req_valid && !req_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_err   = rsp_valid && (status != bmhq_pkg::ST_OK);
  assign rsp_empty = rsp_valid && (status == bmhq_pkg::ST_EMPTY);
  assign rsp_full  = rsp_valid && (status == bmhq_pkg::ST_FULL);
  assign req_word  = {kind, key, tag};
  assign rsp_word  = {status, out_key, out_tag, occupancy};

  // waiting request holds
  `ASSERT_NEXT(a_req_hold, clk, rst, req_stall, req_valid && $stable(req_word))

  // stalled response holds
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_stall, rsp_valid && $stable(rsp_word))

  // rejected transaction carries no entry
  `ASSERT_IMPLY(a_err_zero, clk, rst, rsp_err, out_key == '0 && out_tag == '0)

  `ASSERT_IMPLY(a_empty_occ, clk, rst, rsp_empty, occupancy == '0)

  `ASSERT_IMPLY(a_full_occ, clk, rst, rsp_full, occupancy == bmhq_pkg::OCC_W'(bmhq_pkg::DEPTH))

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .kind      (kind),
  .key       (key),
  .tag       (tag),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .status    (status),
  .out_key   (out_key),
  .out_tag   (out_tag),
  .occupancy (occupancy)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic signed [bmhq_pkg::KEY_W-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [bmhq_pkg::KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [bmhq_pkg::TAG_W-1:0] TAG_MASK =
    (bmhq_pkg::TAG_BITS >= bmhq_pkg::TAG_W) ? {bmhq_pkg::TAG_W{1'b1}} :
    bmhq_pkg::TAG_W'((1 << bmhq_pkg::TAG_BITS) - 1);

  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    bmhq_pkg::status_t                 st;
    logic signed [bmhq_pkg::KEY_W-1:0] k;
    logic [bmhq_pkg::TAG_W-1:0]        t;
    logic [bmhq_pkg::OCC_W-1:0]        occ;
  } heap_rsp_t;

  class heap_scoreboard;
    logic signed [bmhq_pkg::KEY_W-1:0] keys [bmhq_pkg::DEPTH+1];
    logic [bmhq_pkg::TAG_W-1:0]        tags [bmhq_pkg::DEPTH+1];
    int unsigned                       count;
    heap_rsp_t                         pending_q[$];
    int errors, checked, peak;
    int n_push, n_pop, n_empty, n_full;

    function new();
      count = 0;
      errors = 0;
      checked = 0;
      peak = 0;
      n_push = 0;
      n_pop = 0;
      n_empty = 0;
      n_full = 0;
    endfunction

    // equal keys: an even tag goes first
    function bit comes_first(logic signed [bmhq_pkg::KEY_W-1:0] ka,
                             logic [bmhq_pkg::TAG_W-1:0] ta,
                             logic signed [bmhq_pkg::KEY_W-1:0] kb);
      if (ka == kb) return !ta[0];
      return ka < kb;
    endfunction

    function void insert_entry(logic signed [bmhq_pkg::KEY_W-1:0] k,
                               logic [bmhq_pkg::TAG_W-1:0] t);
      int unsigned i;
      i = ++count;
      while (i > 1 && comes_first(k, t, keys[i >> 1])) begin
        keys[i] = keys[i >> 1];
        tags[i] = tags[i >> 1];
        i = i >> 1;
      end
      keys[i] = k;
      tags[i] = t;
    endfunction

    function void remove_root();
      logic signed [bmhq_pkg::KEY_W-1:0] k;
      logic [bmhq_pkg::TAG_W-1:0]        t;
      int unsigned                       i, c;
      k = keys[count];
      t = tags[count];
      i = 1;
      c = 2;
      count--;
      while (c <= count) begin
        if (c < count && comes_first(keys[c+1], tags[c+1], keys[c])) c++;
        if (!comes_first(keys[c], tags[c], k)) break;
        keys[i] = keys[c];
        tags[i] = tags[c];
        i = c;
        c = i << 1;
      end
      keys[i] = k;
      tags[i] = t;
    endfunction

    function void note_request(logic op, logic signed [bmhq_pkg::KEY_W-1:0] k,
                               logic [bmhq_pkg::TAG_W-1:0] t);
      heap_rsp_t e;
      e.st = bmhq_pkg::ST_OK;
      e.k  = '0;
      e.t  = '0;
      if (op == bmhq_pkg::KIND_PUSH) begin
        if (count >= bmhq_pkg::DEPTH) begin
          e.st = bmhq_pkg::ST_FULL;
          n_full++;
        end else begin
          insert_entry(k, t & TAG_MASK);
          n_push++;
        end
      end else begin
        if (count == 0) begin
          e.st = bmhq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          e.k = keys[1];
          e.t = tags[1];
          remove_root();
          n_pop++;
        end
      end
      if (count > peak) peak = count;
      e.occ = bmhq_pkg::OCC_W'(count);
      pending_q.push_back(e);
    endfunction

    task report(string field, logic [bmhq_pkg::KEY_W-1:0] got,
                logic [bmhq_pkg::KEY_W-1:0] want);
      errors++;
      $display("mismatch on transaction %0d: %s got %h expected %h",
               checked, field, got, want);
    endtask

    task check_response(logic [bmhq_pkg::STS_W-1:0] st,
                        logic signed [bmhq_pkg::KEY_W-1:0] k,
                        logic [bmhq_pkg::TAG_W-1:0] t,
                        logic [bmhq_pkg::OCC_W-1:0] occ);
      heap_rsp_t e;
      if (pending_q.size() == 0) begin
        report("unexpected transaction, status", bmhq_pkg::KEY_W'(st), '0);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.st) report("status", bmhq_pkg::KEY_W'(st), bmhq_pkg::KEY_W'(e.st));
      if (k !== e.k) report("out_key", k, e.k);
      if (t !== e.t) report("out_tag", bmhq_pkg::KEY_W'(t), bmhq_pkg::KEY_W'(e.t));
      if (occ !== e.occ)
        report("occupancy", bmhq_pkg::KEY_W'(occ), bmhq_pkg::KEY_W'(e.occ));
      checked++;
    endtask
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              req_valid = 1'b0;
  logic                              req_ready;
  logic                              kind = bmhq_pkg::KIND_PUSH;
  logic signed [bmhq_pkg::KEY_W-1:0] key = '0;
  logic [bmhq_pkg::TAG_W-1:0]        tag = '0;
  logic                              rsp_valid;
  logic                              rsp_ready = 1'b0;
  logic [bmhq_pkg::STS_W-1:0]        status;
  logic signed [bmhq_pkg::KEY_W-1:0] out_key;
  logic [bmhq_pkg::TAG_W-1:0]        out_tag;
  logic [bmhq_pkg::OCC_W-1:0]        occupancy;

  heap_scoreboard sb = new();
  int snd_idle_pct = 13;
  int rcv_idle_pct = 86;
  int cycle_cnt = 0;
  logic rcv_hold = 1'b0;
  event hold_go;

  binary_min_heap_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .kind      (kind),
    .key       (key),
    .tag       (tag),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .occupancy (occupancy)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  // long receiver stall
  always begin
    @(hold_go);
    rcv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rcv_hold <= 1'b0;
  end

  // response side: check, then decide ready for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready)
        sb.check_response(status, out_key, out_tag, occupancy);
      if (rcv_hold) begin
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send(logic op, logic signed [bmhq_pkg::KEY_W-1:0] k,
                      logic [bmhq_pkg::TAG_W-1:0] t);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    kind      <= op;
    key       <= k;
    tag       <= t;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(op, k, t);
  endtask

  task automatic push(logic signed [bmhq_pkg::KEY_W-1:0] k,
                      logic [bmhq_pkg::TAG_W-1:0] t);
    send(bmhq_pkg::KIND_PUSH, k, t);
  endtask

  task automatic pop();
    send(bmhq_pkg::KIND_POP, {$urandom, $urandom}, bmhq_pkg::TAG_W'($urandom));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [bmhq_pkg::KEY_W-1:0] pick_key();
    int unsigned r;
    logic signed [bmhq_pkg::KEY_W-1:0] k;
    r = $urandom_range(99);
    k = {$urandom, $urandom};
    if (r < 35) begin
      k = longint'($urandom_range(8)) - 64'sd4;
    end else if (r < 45) begin
      case ($urandom_range(3))
        0: k = KEY_MIN;
        1: k = KEY_MIN + 1;
        2: k = KEY_MAX;
        default: k = KEY_MAX - 1;
      endcase
    end
    return k;
  endfunction

  function automatic logic [bmhq_pkg::TAG_W-1:0] pick_tag();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return bmhq_pkg::TAG_W'($urandom);
    endcase
  endfunction

  task automatic run_mix(int n);
    int push_pct;
    repeat (n) begin
      if (sb.count < 8) push_pct = 70;
      else if (sb.count > 200) push_pct = 35;
      else push_pct = 55;
      if ($urandom_range(99) < push_pct) push(pick_key(), pick_tag());
      else pop();
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pop, key extremes, equal-key tie cases, drain
    pop();
    push(KEY_MAX, 16'hFFFF);
    push(KEY_MIN, 16'h0000);
    push(64'sd0, 16'h0001);
    push(64'sd0, 16'h0002);
    push(64'sd0, 16'h0004);
    push(64'sd0, 16'h0003);
    push(-64'sd1, 16'hAAAA);
    push(64'sd1, 16'h5555);
    push(KEY_MIN, 16'hFFFF);
    push(KEY_MAX, 16'h0000);
    repeat (10) pop();
    pop();

    run_mix(50);
    -> hold_go;
    run_mix(70);
    wait_drained();

    snd_idle_pct = 86;
    rcv_idle_pct = 13;
    run_mix(80);
    wait_drained();

    // fill to capacity, push on full, then deep pops and a mix near full
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (sb.count < bmhq_pkg::DEPTH) push(pick_key(), pick_tag());
    repeat (2) push(pick_key(), pick_tag());
    pop();
    push(KEY_MIN, 16'h0001);
    push(KEY_MAX, 16'h0000);
    repeat (16) pop();

    run_mix(30);
    wait_drained();
    repeat (30) @(posedge clk);

    $display("ran %0d pushes, %0d pops, %0d pops on empty, %0d pushes on full",
             sb.n_push, sb.n_pop, sb.n_empty, sb.n_full);
    $display("peak occupancy %0d, %0d transactions checked, %0d mismatches",
             sb.peak, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/bmhq_pkg.sv
hdl/bmhq_ctrl.sv
hdl/bmhq_dp.sv
hdl/binary_min_heap_queue.sv
hdl/bmhq_checker.sv
tb/tb.sv
